// ===== design/three_level_priority_queue_defines.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge out of reset.
`define TLPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TLPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TLPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TLPQ_ASSERT(lbl, prop, msg)
`define TLPQ_ASSERT_IMP(lbl, ante, cons, msg)
`define TLPQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/tlpq_pkg.sv =====
package tlpq_pkg;

  localparam int unsigned NUM_LEVELS = 3;
  localparam int unsigned TOTAL_W    = 6;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Level codes as seen on the ports
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd1;
  localparam logic [1:0] LVL_MID  = 2'd2;
  localparam logic [1:0] LVL_LOW  = 2'd3;

  // Internal level slots, highest priority first
  localparam logic [1:0] IDX_HIGH = 2'd0;
  localparam logic [1:0] IDX_MID  = 2'd1;
  localparam logic [1:0] IDX_LOW  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } lvl_cmd_t;

  function automatic logic [1:0] idx_to_level(logic [1:0] idx);
    logic [1:0] lvl;
    unique case (idx)
      IDX_HIGH: lvl = LVL_HIGH;
      IDX_MID:  lvl = LVL_MID;
      default:  lvl = LVL_LOW;
    endcase
    return lvl;
  endfunction

endpackage

// ===== design/tlpq_level.sv =====
`include "three_level_priority_queue_defines.svh"

module tlpq_level #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlpq_pkg::lvl_cmd_t             cmd_i,
  input  logic [DATA_W-1:0]              wdata_i,
  output logic [$clog2(DEPTH+1)-1:0]     count_o,
  output logic [DATA_W-1:0]              head_o
);
  import tlpq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] head_q;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (cmd_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      count_d  = count_q - CNT_W'(1);
    end
    if (cmd_i.push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      count_d  = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // Head register always tracks the entry at the read pointer; forward a
  // write that lands there in the same cycle (push into an empty ring).
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    if (cmd_i.push && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= wdata_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  assign count_o = count_q;
  assign head_o  = head_q;

  `TLPQ_ASSERT_IMP(a_no_push_full, cmd_i.push, count_q != CNT_W'(DEPTH), "push into full ring")
  `TLPQ_ASSERT_IMP(a_no_pop_empty, cmd_i.pop, count_q != '0, "pop from empty ring")
  `TLPQ_ASSERT(a_push_pop_excl, !(cmd_i.push && cmd_i.pop), "push and pop in one cycle")
  `TLPQ_ASSERT_IMP(a_empty_ptrs, count_q == '0, rd_ptr_q == wr_ptr_q, "empty ring with split pointers")

endmodule

// ===== design/three_level_priority_queue.sv =====
// Channel | Handshake               | Payload
// --------+-------------------------+----------------------------------------------
// in      | in_valid_i / in_stall_o | req_type_i, item_data_i, item_level_i
// out     | out_valid_o/out_stall_i | out_data_o, out_level_o, front_data_o,
//         |                         | front_level_o, total_count_o, is_empty_o, status_o
//
// One request per cycle while the result is not stalled; each request gives one result.
// The request updates pointers and counts at acceptance; the result register picks
// up the new front when the request stage advances, from the per-level head registers,
// which read each ring memory at its next read pointer.
// Reset clears pointers, counts and valid flags; ring contents are not cleared.
// A stalled result holds the request stage, and that in turn stalls the input.
`include "three_level_priority_queue_defines.svh"

module three_level_priority_queue #(
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [DATA_WIDTH-1:0]          item_data_i,
  input  logic [1:0]                     item_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [DATA_WIDTH-1:0]          out_data_o,
  output logic [1:0]                     out_level_o,
  output logic [DATA_WIDTH-1:0]          front_data_o,
  output logic [1:0]                     front_level_o,
  output logic [tlpq_pkg::TOTAL_W-1:0]   total_count_o,
  output logic                           is_empty_o,
  output logic [1:0]                     status_o
);
  import tlpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 2;

  lvl_cmd_t              cmd   [NUM_LEVELS];
  logic [CNT_W-1:0]      count [NUM_LEVELS];
  logic [DATA_WIDTH-1:0] head  [NUM_LEVELS];

  logic                  in_xfer;
  logic                  s1_adv;
  logic [1:0]            enq_idx;
  logic [1:0]            deq_idx;
  logic                  deq_found;
  logic [SUM_W-1:0]      total;

  logic                  s1_valid_q;
  logic [DATA_WIDTH-1:0] s1_data_q, s1_data_d;
  logic [1:0]            s1_level_q, s1_level_d;
  logic [1:0]            s1_status_q, s1_status_d;

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [1:0]            out_level_q;
  logic [DATA_WIDTH-1:0] out_front_data_q;
  logic [1:0]            out_front_level_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic                  out_is_empty_q;
  logic [1:0]            out_status_q;

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
    tlpq_level #(
      .DEPTH  (LEVEL_DEPTH),
      .DATA_W (DATA_WIDTH)
    ) u_level (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[l]),
      .wdata_i (item_data_i),
      .count_o (count[l]),
      .head_o  (head[l])
    );
  end

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign total = SUM_W'(count[0]) + SUM_W'(count[1]) + SUM_W'(count[2]);

  // Highest non-empty level: dequeue target now, and front once the state settles.
  always_comb begin
    deq_found = 1'b0;
    deq_idx   = IDX_LOW;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count[l] != '0) begin
        deq_found = 1'b1;
        deq_idx   = 2'(l);
      end
    end
  end

  always_comb begin
    priority if (item_level_i == LVL_HIGH) begin
      enq_idx = IDX_HIGH;
    end else if (item_level_i == LVL_MID) begin
      enq_idx = IDX_MID;
    end else begin
      enq_idx = IDX_LOW;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      cmd[l] = '0;
    end
    s1_data_d   = '0;
    s1_level_d  = LVL_NONE;
    s1_status_d = ST_OK;
    if (req_type_i == REQ_DEQ) begin
      if (deq_found) begin
        s1_data_d  = head[deq_idx];
        s1_level_d = idx_to_level(deq_idx);
        cmd[deq_idx].pop = in_xfer;
      end else begin
        s1_status_d = ST_EMPTY;
      end
    end else begin
      if (count[enq_idx] == CNT_W'(LEVEL_DEPTH)) begin
        s1_status_d = ST_FULL;
      end else begin
        cmd[enq_idx].push = in_xfer;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Sample the front when the request stage advances, after the request has updated the rings.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q   <= s1_data_d;
      s1_level_q  <= s1_level_d;
      s1_status_q <= s1_status_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q        <= s1_data_q;
      out_level_q       <= s1_level_q;
      out_status_q      <= s1_status_q;
      out_front_data_q  <= deq_found ? head[deq_idx] : '0;
      out_front_level_q <= deq_found ? idx_to_level(deq_idx) : LVL_NONE;
      out_total_q       <= TOTAL_W'(total);
      out_is_empty_q    <= (total == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_level_o   = out_level_q;
  assign front_data_o  = out_front_data_q;
  assign front_level_o = out_front_level_q;
  assign total_count_o = out_total_q;
  assign is_empty_o    = out_is_empty_q;
  assign status_o      = out_status_q;

  `TLPQ_ASSERT_IMP(a_err_no_removal, out_valid_q && (out_status_q != ST_OK), out_level_q == LVL_NONE, "error result reports a removal")
  `TLPQ_ASSERT_IMP(a_empty_no_front, out_valid_q && out_is_empty_q, out_front_level_q == LVL_NONE, "empty queue reports a front item")
  `TLPQ_ASSERT_NXT(a_deq_empty_flag, in_xfer && (req_type_i == REQ_DEQ) && !deq_found, s1_status_q == ST_EMPTY, "dequeue on empty not flagged")

endmodule
